### hw/rtl/qvr_pkg.sv
// Shared widths and beat types for the quaternion vector rotation core.
package qvr_pkg;

  // Input component width (quaternion Q2.14 and vector)
  localparam int CW   = 16;
  // Square and cross products of two components
  localparam int PW   = 2 * CW;
  // Squared norm n, unsigned, up to 4 * 2^30
  localparam int NW   = PW + 1;
  // Unnormalized rotation matrix entries, signed
  localparam int MW   = PW + 3;
  // Matrix entry times vector component, signed
  localparam int MPW  = MW + CW;
  // Dot product sum, signed
  localparam int SUMW = MPW + 1;
  // Magnitude of the dot product (|M v| <= n |v| < 2^49)
  localparam int MAGW = 50;
  // Rounding dividend 2|num| + n
  localparam int DW   = MAGW + 2;
  // Divisor 2n
  localparam int DVW  = NW + 1;
  // Quotient bits: |result| <= |v| < 2^17
  localparam int QW   = 17;
  // Signed result before clipping
  localparam int RW   = QW + 1;
  // Number of vector lanes
  localparam int LANES = 3;

  localparam logic signed [RW-1:0] OUT_MAX = RW'(32767);
  localparam logic signed [RW-1:0] OUT_MIN = -RW'(32768);

  // Beat from the matrix front end into the divider
  typedef struct packed {
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][MAGW-1:0] mag;
    logic [NW-1:0]              n;
    logic                       zero;
  } front_t;

  // Beat from the divider into the output stage
  typedef struct packed {
    logic [LANES-1:0]         neg;
    logic [LANES-1:0][QW-1:0] q;
    logic                     zero;
  } quot_t;

endpackage

### hw/rtl/qvr_front.sv
// Front end: products, rotation matrix, matrix-vector product and magnitude.
module qvr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qvr_pkg::CW-1:0] qx,
  input  logic signed [qvr_pkg::CW-1:0] qy,
  input  logic signed [qvr_pkg::CW-1:0] qz,
  input  logic signed [qvr_pkg::CW-1:0] qw,
  input  logic signed [qvr_pkg::CW-1:0] vx,
  input  logic signed [qvr_pkg::CW-1:0] vy,
  input  logic signed [qvr_pkg::CW-1:0] vz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qvr_pkg::front_t               out_beat
);
  import qvr_pkg::*;

  localparam int NS = 5;

  logic [NS-1:0] vld_r;
  logic [NS:0]   en;

  // Per-stage advance: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  // Stage 1: squares and cross products
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [CW-1:0] v1_r [LANES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx_r  <= qx * qx;
      yy_r  <= qy * qy;
      zz_r  <= qz * qz;
      ww_r  <= qw * qw;
      xy_r  <= qx * qy;
      wz_r  <= qw * qz;
      xz_r  <= qx * qz;
      wy_r  <= qw * qy;
      yz_r  <= qy * qz;
      wx_r  <= qw * qx;
      v1_r[0] <= vx;
      v1_r[1] <= vy;
      v1_r[2] <= vz;
    end
  end

  // Stage 2: norm and unnormalized rotation matrix
  logic [NW-1:0]        n2_r;
  logic signed [MW-1:0] m2_r [LANES][LANES];
  logic signed [CW-1:0] v2_r [LANES];

  logic signed [MW-1:0] exx, eyy, ezz, eww;
  assign exx = MW'(xx_r);
  assign eyy = MW'(yy_r);
  assign ezz = MW'(zz_r);
  assign eww = MW'(ww_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n2_r       <= NW'(xx_r) + NW'(yy_r) + NW'(zz_r) + NW'(ww_r);
      m2_r[0][0] <= eww + exx - eyy - ezz;
      m2_r[1][1] <= eww - exx + eyy - ezz;
      m2_r[2][2] <= eww - exx - eyy + ezz;
      m2_r[0][1] <= (MW'(xy_r) - MW'(wz_r)) <<< 1;
      m2_r[1][0] <= (MW'(xy_r) + MW'(wz_r)) <<< 1;
      m2_r[0][2] <= (MW'(xz_r) + MW'(wy_r)) <<< 1;
      m2_r[2][0] <= (MW'(xz_r) - MW'(wy_r)) <<< 1;
      m2_r[1][2] <= (MW'(yz_r) - MW'(wx_r)) <<< 1;
      m2_r[2][1] <= (MW'(yz_r) + MW'(wx_r)) <<< 1;
      v2_r       <= v1_r;
    end
  end

  // Stage 3: matrix entry times vector component
  logic signed [MPW-1:0] p3_r [LANES][LANES];
  logic [NW-1:0]         n3_r;
  logic                  z3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          p3_r[i][j] <= MPW'(m2_r[i][j]) * MPW'(v2_r[j]);
        end
      end
      n3_r <= n2_r;
      z3_r <= (n2_r == '0);
    end
  end

  // Stage 4: row sums
  logic signed [SUMW-1:0] s4_r [LANES];
  logic [NW-1:0]          n4_r;
  logic                   z4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < LANES; i++) begin
        s4_r[i] <= SUMW'(p3_r[i][0]) + SUMW'(p3_r[i][1]) + SUMW'(p3_r[i][2]);
      end
      n4_r <= n3_r;
      z4_r <= z3_r;
    end
  end

  // Stage 5: sign and magnitude
  front_t f5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < LANES; i++) begin
        f5_r.neg[i] <= s4_r[i][SUMW-1];
        f5_r.mag[i] <= s4_r[i][SUMW-1] ? MAGW'(-s4_r[i]) : MAGW'(s4_r[i]);
      end
      f5_r.n    <= n4_r;
      f5_r.zero <= z4_r;
    end
  end

  assign out_beat = f5_r;

endmodule

### hw/rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes.
module qvr_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qvr_pkg::front_t  in_beat,
  output logic             out_valid,
  input  logic             out_ready,
  output qvr_pkg::quot_t   out_beat
);
  import qvr_pkg::*;

  // Prep stage plus one stage per quotient bit
  localparam int NS = QW + 1;

  logic [NS-1:0] vld_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  logic [DW-1:0]  rem_r [NS][LANES];
  logic [QW-1:0]  quo_r [NS][LANES];
  logic [DVW-1:0] dvs_r [NS];
  logic [LANES-1:0] neg_r [NS];
  logic             zero_r [NS];

  // Prep: dividend 2|num| + n gives round-half-away on the floor quotient by 2n
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        rem_r[0][i] <= {1'b0, in_beat.mag[i], 1'b0} + DW'(in_beat.n);
        quo_r[0][i] <= '0;
      end
      dvs_r[0]  <= {in_beat.n, 1'b0};
      neg_r[0]  <= in_beat.neg;
      zero_r[0] <= in_beat.zero;
    end
  end

  // Bit stages: MSB of the quotient first
  for (genvar k = 1; k < NS; k++) begin : g_bit
    localparam int BIT = QW - k;
    logic [DW-1:0] trial;
    assign trial = DW'(dvs_r[k-1]) << BIT;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        for (int i = 0; i < LANES; i++) begin
          if (rem_r[k-1][i] >= trial) begin
            rem_r[k][i] <= rem_r[k-1][i] - trial;
            quo_r[k][i] <= quo_r[k-1][i] | (QW'(1) << BIT);
          end else begin
            rem_r[k][i] <= rem_r[k-1][i];
            quo_r[k][i] <= quo_r[k-1][i];
          end
        end
        dvs_r[k]  <= dvs_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_beat.q[i] = quo_r[NS-1][i];
    end
    out_beat.neg  = neg_r[NS-1];
    out_beat.zero = zero_r[NS-1];
  end

endmodule

### hw/rtl/quaternion_vector_rotate_core.sv
// Top level of the quaternion vector rotation core.
// Rotates a 16-bit vector by the normalized Q2.14 quaternion: result = M v / |q|^2,
// rounded half away from zero and clipped to 16 bits, with saturated and
// zero_quaternion flags. Fully pipelined: one beat accepted per cycle unless the output
// stalls, passing through 5 front-end stages for products, matrix, matrix-vector
// product and magnitude; a prep stage and 17 one-bit stages of the restoring divider;
// and one output stage for sign, clipping and flags. Every stage
// carries its own valid bit, so bubbles are squeezed out while the output stalls.
module quaternion_vector_rotate_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qvr_pkg::CW-1:0] in_quat_x,
  input  logic signed [qvr_pkg::CW-1:0] in_quat_y,
  input  logic signed [qvr_pkg::CW-1:0] in_quat_z,
  input  logic signed [qvr_pkg::CW-1:0] in_quat_w,
  input  logic signed [qvr_pkg::CW-1:0] in_vec_x,
  input  logic signed [qvr_pkg::CW-1:0] in_vec_y,
  input  logic signed [qvr_pkg::CW-1:0] in_vec_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [qvr_pkg::CW-1:0] out_x,
  output logic signed [qvr_pkg::CW-1:0] out_y,
  output logic signed [qvr_pkg::CW-1:0] out_z,
  output logic                          out_saturated,
  output logic                          out_zero_quaternion
);
  import qvr_pkg::*;

  logic   fr_valid, fr_ready;
  front_t fr_beat;
  logic   dq_valid, dq_ready;
  quot_t  dq_beat;

  qvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .qx        (in_quat_x),
    .qy        (in_quat_y),
    .qz        (in_quat_z),
    .qw        (in_quat_w),
    .vx        (in_vec_x),
    .vy        (in_vec_y),
    .vz        (in_vec_z),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_beat  (fr_beat)
  );

  qvr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_beat   (fr_beat),
    .out_valid (dq_valid),
    .out_ready (dq_ready),
    .out_beat  (dq_beat)
  );

  // Output stage: apply sign, clip, zero override
  logic                 out_valid_r;
  logic signed [CW-1:0] res_r [LANES];
  logic                 sat_r, zq_r;
  logic                 en_out;

  logic signed [RW-1:0] sres [LANES];
  logic signed [CW-1:0] cres [LANES];
  logic [LANES-1:0]     clip;

  assign en_out   = !out_valid_r || out_ready;
  assign dq_ready = en_out;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sres[i] = dq_beat.neg[i] ? -RW'(dq_beat.q[i]) : RW'(dq_beat.q[i]);
      if (sres[i] > OUT_MAX) begin
        cres[i] = CW'(OUT_MAX);
        clip[i] = 1'b1;
      end else if (sres[i] < OUT_MIN) begin
        cres[i] = CW'(OUT_MIN);
        clip[i] = 1'b1;
      end else begin
        cres[i] = CW'(sres[i]);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      for (int i = 0; i < LANES; i++) begin
        res_r[i] <= dq_beat.zero ? '0 : cres[i];
      end
      sat_r <= !dq_beat.zero && (|clip);
      zq_r  <= dq_beat.zero;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_x               = res_r[0];
  assign out_y               = res_r[1];
  assign out_z               = res_r[2];
  assign out_saturated       = sat_r;
  assign out_zero_quaternion = zq_r;

`ifndef SYNTHESIS
  // Zero quaternion beats carry a zero vector and no clip flag
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_quaternion |->
      out_x == '0 && out_y == '0 && out_z == '0 && !out_saturated)
    else $error("zero quaternion beat with nonzero result");

  // A clip flag means some component sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == 16'sh7fff || out_x == 16'sh8000 ||
      out_y == 16'sh7fff || out_y == 16'sh8000 ||
      out_z == 16'sh7fff || out_z == 16'sh8000)
    else $error("saturated flag without a clipped component");

  // With the output stage empty the whole pipeline must be able to advance
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
